/* rtl/cps_pkg.sv */
// Shared types and constants for the cab panel start-up sequencer and display.
// Holds the transaction payload structs, register indexes and segment patterns.
// No dependencies.
package cps_pkg;

  // Register indexes on the configuration port (byte address / 4)
  localparam logic [2:0] REG_SPEED_LIMIT   = 3'd0;
  localparam logic [2:0] REG_SPEED_MARGIN  = 3'd1;
  localparam logic [2:0] REG_FIRST_MSG     = 3'd2;
  localparam logic [2:0] REG_BLANK_GAP     = 3'd3;
  localparam logic [2:0] REG_SECOND_MSG    = 3'd4;
  localparam logic [2:0] REG_LAMP_TEST     = 3'd5;
  localparam logic [2:0] REG_SWEEP_PERIOD  = 3'd6;

  // Register reset values
  localparam logic [8:0]  SPEED_LIMIT_RST  = 9'd0;
  localparam logic [5:0]  SPEED_MARGIN_RST = 6'd5;
  localparam logic [15:0] FIRST_MSG_RST    = 16'd2000;
  localparam logic [15:0] BLANK_GAP_RST    = 16'd2000;
  localparam logic [15:0] SECOND_MSG_RST   = 16'd2000;
  localparam logic [15:0] LAMP_TEST_RST    = 16'd3000;
  localparam logic [7:0]  SWEEP_PERIOD_RST = 8'd2;

  // Characters per message
  localparam int unsigned MsgLen = 6;

  // Message currently loaded into the display
  typedef enum logic [1:0] {
    MSG_BLANK  = 2'd0,
    MSG_FIRST  = 2'd1,
    MSG_SECOND = 2'd2,
    MSG_TEST   = 2'd3
  } msg_e;

  // Seven-segment patterns, bit0 A .. bit6 G, bit7 dot
  localparam logic [7:0] TEXT_FIRST  [MsgLen] = '{8'h73, 8'h77, 8'h00, 8'h66, 8'h3F, 8'h3F};
  localparam logic [7:0] TEXT_SECOND [MsgLen] = '{8'h3E, 8'h39, 8'h00, 8'h6D, 8'h06, 8'h5B};
  localparam logic [7:0] TEXT_TEST   [MsgLen] = '{8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F};

  // Input transaction
  typedef struct packed {
    logic       panel_unlocked;
    logic       validate_on;
    logic [8:0] speed_reading;
  } cps_in_t;

  // Result transaction
  typedef struct packed {
    logic [2:0] mode;
    logic [5:0] digit_enable;
    logic [7:0] segment_lines;
    logic       blink_lamp;
    logic       urgency;
  } cps_out_t;

  // Segment pattern of one digit position of a message; blank beyond the text
  function automatic logic [7:0] seg_pattern(msg_e msg, logic [3:0] pos);
    logic [7:0] pat;
    pat = 8'h00;
    if (pos < 4'(MsgLen)) begin
      case (msg)
        MSG_FIRST:  pat = TEXT_FIRST[pos[2:0]];
        MSG_SECOND: pat = TEXT_SECOND[pos[2:0]];
        MSG_TEST:   pat = TEXT_TEST[pos[2:0]];
        default:    pat = 8'h00;
      endcase
    end
    return pat;
  endfunction

endpackage

/* rtl/cab_panel_sequencer_display.sv */
// Cab panel start-up sequencer with a multiplexed seven-segment display driver.
// Top level: tick channel in, display/status channel out, register port.
// Depends on cps_pkg.
//
// Each input transaction is one 1 ms tick; the block returns exactly one result
// transaction per tick, in the cycle after acceptance, and takes a new tick every
// clock cycle while the result side keeps up. All per-tick work (sequencer step,
// lock check, lamp phase, digit sweep) is a single pass of logic that updates
// the state registers, which also serve as the result register; a finished
// result may wait at the output while the next tick is accepted in the cycle it
// is taken. Registers: 0 speed limit, 1 speed margin, 2 first message time,
// 3 blank gap time, 4 second message time, 5 lamp test time, 6 sweep period,
// at byte addresses 4*i; write them only while no tick is in flight.
module cab_panel_sequencer_display #(
  parameter int unsigned DIGIT_COUNT     = 6,
  parameter int unsigned BLINK_PERIOD_MS = 333
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // tick channel
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cps_pkg::cps_in_t in_data_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cps_pkg::cps_out_t out_data_o,
  // register port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cps_pkg::*;

  localparam int unsigned IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned PhW  = $clog2(BLINK_PERIOD_MS);
  localparam logic [PhW-1:0]  PhaseLast = PhW'(BLINK_PERIOD_MS - 1);
  localparam logic [PhW-1:0]  PhaseHalf = PhW'(BLINK_PERIOD_MS / 2);
  localparam logic [IdxW-1:0] IdxLast   = IdxW'(DIGIT_COUNT - 1);

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_FIRST    = 3'd1,
    MODE_BLANK    = 3'd2,
    MODE_SECOND   = 3'd3,
    MODE_LAMPTEST = 3'd4,
    MODE_WAITVAL  = 3'd5,
    MODE_IDLE     = 3'd6,
    MODE_URGENCY  = 3'd7
  } mode_e;

  // Configuration registers
  logic [8:0]  speed_limit_q;
  logic [5:0]  speed_margin_q;
  logic [15:0] first_msg_q;
  logic [15:0] blank_gap_q;
  logic [15:0] second_msg_q;
  logic [15:0] lamp_test_q;
  logic [7:0]  sweep_period_q;

  // Sequencer and display state
  mode_e          mode_q, mode_d;
  logic [15:0]    elapsed_q, elapsed_d;
  msg_e           msg_q, msg_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic           run_q, run_d;
  logic [7:0]     cnt_q, cnt_d;
  logic [5:0]     drive_q, drive_d;
  logic [7:0]     seg_q, seg_d;
  logic           blink_en_q, blink_en_d;
  logic [PhW-1:0] phase_q, phase_d;
  logic           level_q, level_d;
  logic           urg_q, urg_d;
  logic           out_valid_q;

  logic           accept;
  logic           cfg_write;
  logic [15:0]    duration;
  logic           time_up;
  logic [9:0]     speed_cap;
  logic [8:0]     cnt_inc;
  logic [IdxW-1:0] idx_next;
  logic [7:0]     next_pat;

  // Handshake: take a tick whenever the result slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Register read-back
  always_comb begin
    case (paddr[4:2])
      REG_SPEED_LIMIT:  prdata = {23'd0, speed_limit_q};
      REG_SPEED_MARGIN: prdata = {26'd0, speed_margin_q};
      REG_FIRST_MSG:    prdata = {16'd0, first_msg_q};
      REG_BLANK_GAP:    prdata = {16'd0, blank_gap_q};
      REG_SECOND_MSG:   prdata = {16'd0, second_msg_q};
      REG_LAMP_TEST:    prdata = {16'd0, lamp_test_q};
      REG_SWEEP_PERIOD: prdata = {24'd0, sweep_period_q};
      default:          prdata = 32'd0;
    endcase
  end

  // Select the running step's duration
  always_comb begin
    case (mode_q)
      MODE_FIRST:    duration = first_msg_q;
      MODE_BLANK:    duration = blank_gap_q;
      MODE_SECOND:   duration = second_msg_q;
      MODE_LAMPTEST: duration = lamp_test_q;
      default:       duration = 16'd0;
    endcase
  end

  assign time_up   = (elapsed_q >= duration);
  assign speed_cap = {1'b0, speed_limit_q} + 10'(speed_margin_q);

  // One tick: sequencer, lock, lamp, then digit sweep
  always_comb begin
    mode_d     = mode_q;
    elapsed_d  = elapsed_q;
    msg_d      = msg_q;
    idx_d      = idx_q;
    run_d      = run_q;
    cnt_d      = cnt_q;
    drive_d    = drive_q;
    seg_d      = seg_q;
    blink_en_d = blink_en_q;
    level_d    = level_q;
    urg_d      = urg_q;
    cnt_inc    = 9'd0;
    idx_next   = '0;
    next_pat   = 8'h00;

    // advance the start-up sequence
    case (mode_q)
      MODE_OFF: begin
        if (in_data_i.panel_unlocked) begin
          msg_d      = MSG_FIRST;
          run_d      = 1'b1;
          cnt_d      = 8'd0;
          blink_en_d = 1'b1;
          mode_d     = MODE_FIRST;
          elapsed_d  = 16'd0;
        end
      end
      MODE_FIRST, MODE_BLANK, MODE_SECOND, MODE_LAMPTEST: begin
        if (time_up) begin
          elapsed_d = 16'd0;
          case (mode_q)
            MODE_FIRST: begin
              msg_d   = MSG_BLANK;
              drive_d = 6'd0;
              seg_d   = 8'h00;
              run_d   = 1'b0;
              mode_d  = MODE_BLANK;
            end
            MODE_BLANK: begin
              msg_d  = MSG_SECOND;
              run_d  = 1'b1;
              cnt_d  = 8'd0;
              mode_d = MODE_SECOND;
            end
            MODE_SECOND: begin
              msg_d      = MSG_TEST;
              run_d      = 1'b1;
              cnt_d      = 8'd0;
              blink_en_d = 1'b1;
              mode_d     = MODE_LAMPTEST;
            end
            default: begin
              msg_d   = MSG_BLANK;
              drive_d = 6'd0;
              seg_d   = 8'h00;
              run_d   = 1'b0;
              mode_d  = MODE_WAITVAL;
            end
          endcase
        end else begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end
      MODE_WAITVAL: begin
        if (in_data_i.validate_on) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        if ({1'b0, in_data_i.speed_reading} > speed_cap) begin
          urg_d  = 1'b1;
          mode_d = MODE_URGENCY;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    // force off when the panel is locked
    if (!in_data_i.panel_unlocked) begin
      msg_d      = MSG_BLANK;
      drive_d    = 6'd0;
      seg_d      = 8'h00;
      run_d      = 1'b0;
      blink_en_d = 1'b0;
      mode_d     = MODE_OFF;
    end

    // sample the lamp phase while blinking
    if (blink_en_d) begin
      level_d = (phase_q > PhaseHalf);
    end

    // step the digit multiplexer
    if (run_d) begin
      cnt_inc = {1'b0, cnt_d} + 9'd1;
      if (cnt_inc >= {1'b0, sweep_period_q}) begin
        cnt_d    = 8'd0;
        drive_d  = 6'd0;
        idx_next = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
        idx_d    = idx_next;
        next_pat = seg_pattern(msg_d, 4'(idx_next));
        if (next_pat != 8'h00) begin
          seg_d = next_pat;
          for (int k = 0; k < 6; k++) begin
            drive_d[k] = (4'(idx_next) == 4'(k));
          end
        end
      end else begin
        cnt_d = cnt_inc[7:0];
      end
    end
  end

  // Free-running lamp phase
  assign phase_d = (phase_q == PhaseLast) ? '0 : phase_q + 1'b1;

  // Hold configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q  <= SPEED_LIMIT_RST;
      speed_margin_q <= SPEED_MARGIN_RST;
      first_msg_q    <= FIRST_MSG_RST;
      blank_gap_q    <= BLANK_GAP_RST;
      second_msg_q   <= SECOND_MSG_RST;
      lamp_test_q    <= LAMP_TEST_RST;
      sweep_period_q <= SWEEP_PERIOD_RST;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_SPEED_LIMIT:  speed_limit_q  <= pwdata[8:0];
        REG_SPEED_MARGIN: speed_margin_q <= pwdata[5:0];
        REG_FIRST_MSG:    first_msg_q    <= pwdata[15:0];
        REG_BLANK_GAP:    blank_gap_q    <= pwdata[15:0];
        REG_SECOND_MSG:   second_msg_q   <= pwdata[15:0];
        REG_LAMP_TEST:    lamp_test_q    <= pwdata[15:0];
        REG_SWEEP_PERIOD: sweep_period_q <= pwdata[7:0];
        default: begin
          sweep_period_q <= sweep_period_q;
        end
      endcase
    end
  end

  // Hold state and the result; update on every accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_OFF;
      elapsed_q   <= 16'd0;
      msg_q       <= MSG_BLANK;
      idx_q       <= '0;
      run_q       <= 1'b0;
      cnt_q       <= 8'd0;
      drive_q     <= 6'd0;
      seg_q       <= 8'h00;
      blink_en_q  <= 1'b0;
      phase_q     <= '0;
      level_q     <= 1'b0;
      urg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        mode_q     <= mode_d;
        elapsed_q  <= elapsed_d;
        msg_q      <= msg_d;
        idx_q      <= idx_d;
        run_q      <= run_d;
        cnt_q      <= cnt_d;
        drive_q    <= drive_d;
        seg_q      <= seg_d;
        blink_en_q <= blink_en_d;
        phase_q    <= phase_d;
        level_q    <= level_d;
        urg_q      <= urg_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Drive the result from the state registers
  assign out_valid_o              = out_valid_q;
  assign out_data_o.mode          = mode_q;
  assign out_data_o.digit_enable  = drive_q;
  assign out_data_o.segment_lines = seg_q;
  assign out_data_o.blink_lamp    = level_q;
  assign out_data_o.urgency       = urg_q;

endmodule

/* test/tb_cab_panel_sequencer_display.sv */
// Self-checking testbench for the cab panel start-up sequencer and display driver.
// Drives 1 ms tick transactions, programs timing registers over APB, predicts every
// result in a local model of the sequencer; depends on cps_pkg and the top level.
module tb_cab_panel_sequencer_display;
  timeunit 1ns;
  timeprecision 1ps;

  import cps_pkg::*;

  localparam int unsigned DigitCount  = 6;
  localparam int unsigned BlinkPeriod = 333;
  localparam int unsigned RandomTicks = 400;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_FIRST    = 3'd1,
    MODE_BLANK    = 3'd2,
    MODE_SECOND   = 3'd3,
    MODE_LAMPTEST = 3'd4,
    MODE_WAITVAL  = 3'd5,
    MODE_IDLE     = 3'd6,
    MODE_URGENCY  = 3'd7
  } panel_mode_e;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  cps_in_t     in_data = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  cps_out_t    out_data_o;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // Panel model: configuration
  logic [8:0]  cfg_limit  = SPEED_LIMIT_RST;
  logic [5:0]  cfg_margin = SPEED_MARGIN_RST;
  logic [15:0] cfg_first  = FIRST_MSG_RST;
  logic [15:0] cfg_blank  = BLANK_GAP_RST;
  logic [15:0] cfg_second = SECOND_MSG_RST;
  logic [15:0] cfg_lamp   = LAMP_TEST_RST;
  logic [7:0]  cfg_sweep  = SWEEP_PERIOD_RST;

  // Panel model: state
  panel_mode_e m_mode      = MODE_OFF;
  int unsigned m_elapsed   = 0;
  logic [7:0]  m_pattern [DigitCount] = '{default: 8'h00};
  int unsigned m_digit_idx = 0;
  bit          m_sweep_on  = 1'b0;
  int unsigned m_sweep_cnt = 0;
  logic [5:0]  m_digit_drv = '0;
  logic [7:0]  m_segment   = '0;
  bit          m_blink_on  = 1'b0;
  int unsigned m_blink_ph  = 0;
  logic        m_blink_lvl = 1'b0;
  logic        m_urgency   = 1'b0;

  cps_out_t    panel_result_q [$];
  int unsigned error_count = 0;
  int unsigned burst_left  = 0;
  logic [7:0]  stall_phase = '0;

  cab_panel_sequencer_display #(
    .DIGIT_COUNT    (DigitCount),
    .BLINK_PERIOD_MS(BlinkPeriod)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Load a message into the digit patterns and restart the sweep
  function automatic void load_message(input msg_e which);
    for (int i = 0; i < DigitCount; i++) begin
      case (which)
        MSG_FIRST:  m_pattern[i] = TEXT_FIRST[i];
        MSG_SECOND: m_pattern[i] = TEXT_SECOND[i];
        MSG_TEST:   m_pattern[i] = TEXT_TEST[i];
        default:    m_pattern[i] = 8'h00;
      endcase
    end
    m_sweep_on  = 1'b1;
    m_sweep_cnt = 0;
  endfunction

  // Turn the display dark and stop the sweep; the digit index is kept
  function automatic void clear_display();
    for (int i = 0; i < DigitCount; i++) m_pattern[i] = 8'h00;
    m_digit_drv = '0;
    m_segment   = '0;
    m_sweep_on  = 1'b0;
  endfunction

  // Timed step: leave once the elapsed count already reached the duration
  function automatic bit phase_done(input logic [15:0] duration);
    if (m_elapsed >= int'(duration)) begin
      m_elapsed = 0;
      return 1'b1;
    end
    m_elapsed++;
    return 1'b0;
  endfunction

  function automatic void enter_mode(input panel_mode_e next);
    m_mode    = next;
    m_elapsed = 0;
  endfunction

  // Advance the panel model by one tick and queue the result it shows
  function automatic void predict_panel_tick(input cps_in_t tick);
    cps_out_t res;
    case (m_mode)
      MODE_OFF: if (tick.panel_unlocked) begin
        load_message(MSG_FIRST);
        m_blink_on = 1'b1;
        enter_mode(MODE_FIRST);
      end
      MODE_FIRST: if (phase_done(cfg_first)) begin
        clear_display();
        enter_mode(MODE_BLANK);
      end
      MODE_BLANK: if (phase_done(cfg_blank)) begin
        load_message(MSG_SECOND);
        enter_mode(MODE_SECOND);
      end
      MODE_SECOND: if (phase_done(cfg_second)) begin
        load_message(MSG_TEST);
        m_blink_on = 1'b1;
        enter_mode(MODE_LAMPTEST);
      end
      MODE_LAMPTEST: if (phase_done(cfg_lamp)) begin
        clear_display();
        enter_mode(MODE_WAITVAL);
      end
      MODE_WAITVAL: if (tick.validate_on) m_mode = MODE_IDLE;
      MODE_IDLE: if (int'(tick.speed_reading) > int'(cfg_limit) + int'(cfg_margin)) begin
        m_urgency = 1'b1;
        m_mode    = MODE_URGENCY;
      end
      default: ;
    endcase

    // Lock wins over the sequencer
    if (!tick.panel_unlocked) begin
      clear_display();
      m_blink_on = 1'b0;
      m_mode     = MODE_OFF;
    end

    // Lamp phase runs on every tick; the level holds while disabled
    if (m_blink_on) m_blink_lvl = (m_blink_ph > BlinkPeriod / 2);
    m_blink_ph++;
    if (m_blink_ph >= BlinkPeriod) m_blink_ph = 0;

    // Digit sweep; a blank digit stays dark and the segments keep their value
    if (m_sweep_on) begin
      m_sweep_cnt++;
      if (m_sweep_cnt >= int'(cfg_sweep)) begin
        m_sweep_cnt = 0;
        m_digit_drv = '0;
        m_digit_idx = (m_digit_idx + 1 >= DigitCount) ? 0 : m_digit_idx + 1;
        if (m_pattern[m_digit_idx] != 8'h00) begin
          m_segment   = m_pattern[m_digit_idx];
          m_digit_drv = 6'(1 << m_digit_idx);
        end
      end
    end

    res.mode          = m_mode;
    res.digit_enable  = m_digit_drv;
    res.segment_lines = m_segment;
    res.blink_lamp    = m_blink_lvl;
    res.urgency       = m_urgency;
    panel_result_q.push_back(res);
  endfunction

  function automatic cps_in_t make_tick(input logic unlocked, input logic validate,
                                        input logic [8:0] speed);
    cps_in_t t;
    t.panel_unlocked = unlocked;
    t.validate_on    = validate;
    t.speed_reading  = speed;
    return t;
  endfunction

  // Send one tick transaction; idle between bursts of random length
  task automatic send_tick(input cps_in_t tick);
    in_valid <= 1'b1;
    in_data  <= tick;
    do @(posedge clk_i); while (!in_ready_o);
    predict_panel_tick(tick);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
    end
  endtask

  // Hold the tick channel until every predicted result has arrived
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (panel_result_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // APB write: setup then access; mirror the value into the model
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_SPEED_LIMIT:  cfg_limit  = val[8:0];
      REG_SPEED_MARGIN: cfg_margin = val[5:0];
      REG_FIRST_MSG:    cfg_first  = val[15:0];
      REG_BLANK_GAP:    cfg_blank  = val[15:0];
      REG_SECOND_MSG:   cfg_second = val[15:0];
      REG_LAMP_TEST:    cfg_lamp   = val[15:0];
      REG_SWEEP_PERIOD: cfg_sweep  = val[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_with_ends(input int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Mostly short phases so the sequence reaches idle; now and then the longest
  function automatic logic [31:0] pick_duration();
    return ($urandom_range(0, 15) == 0) ? 32'd65535 : 32'($urandom_range(0, 6));
  endfunction

  task automatic write_random_setup();
    logic [31:0] sweep;
    case ($urandom_range(0, 9))
      0:       sweep = 32'd0;
      1:       sweep = 32'd255;
      default: sweep = $urandom_range(1, 3);
    endcase
    write_reg(REG_SPEED_LIMIT, pick_with_ends(511));
    write_reg(REG_SPEED_MARGIN, pick_with_ends(63));
    write_reg(REG_FIRST_MSG, pick_duration());
    write_reg(REG_BLANK_GAP, pick_duration());
    write_reg(REG_SECOND_MSG, pick_duration());
    write_reg(REG_LAMP_TEST, pick_duration());
    write_reg(REG_SWEEP_PERIOD, sweep);
  endtask

  // Reset settings: validate and speed ignored off idle, lock forces off
  task automatic test_ignored_inputs();
    send_tick(make_tick(1'b0, 1'b1, 9'd511));
    send_tick(make_tick(1'b0, 1'b0, 9'd0));
    send_tick(make_tick(1'b1, 1'b1, 9'd511));
    send_tick(make_tick(1'b1, 1'b1, 9'd511));
    send_tick(make_tick(1'b0, 1'b0, 9'd511));
  endtask

  // Shortest first and blank timings, short second and lamp test, sweep period zero, widest speed threshold
  task automatic test_fast_startup();
    wait_results_done();
    write_reg(REG_SPEED_LIMIT, 32'd511);
    write_reg(REG_SPEED_MARGIN, 32'd63);
    write_reg(REG_FIRST_MSG, 32'd0);
    write_reg(REG_BLANK_GAP, 32'd0);
    write_reg(REG_SECOND_MSG, 32'd1);
    write_reg(REG_LAMP_TEST, 32'd2);
    write_reg(REG_SWEEP_PERIOD, 32'd0);
    // off -> first -> blank -> second (2) -> lamp test (3) -> wait validate
    repeat (8) send_tick(make_tick(1'b1, 1'b0, 9'd0));
    send_tick(make_tick(1'b1, 1'b0, 9'd511));
    send_tick(make_tick(1'b1, 1'b1, 9'd0));
    send_tick(make_tick(1'b1, 1'b0, 9'd511));
    send_tick(make_tick(1'b0, 1'b0, 9'd0));
  endtask

  // Longest timings: stay put, then lock out of the message
  task automatic test_long_durations();
    wait_results_done();
    write_reg(REG_FIRST_MSG, 32'd65535);
    write_reg(REG_BLANK_GAP, 32'd65535);
    write_reg(REG_SECOND_MSG, 32'd65535);
    write_reg(REG_LAMP_TEST, 32'd65535);
    write_reg(REG_SWEEP_PERIOD, 32'd255);
    repeat (3) send_tick(make_tick(1'b1, 1'b0, 9'd300));
    send_tick(make_tick(1'b0, 1'b1, 9'd300));
    wait_results_done();
    write_reg(REG_FIRST_MSG, 32'd0);
    write_reg(REG_BLANK_GAP, 32'd0);
    write_reg(REG_SECOND_MSG, 32'd0);
    write_reg(REG_SWEEP_PERIOD, 32'd1);
    repeat (6) send_tick(make_tick(1'b1, 1'b1, 9'd0));
    send_tick(make_tick(1'b0, 1'b0, 9'd0));
  endtask

  // Start-up runs with random timings and content, occasional lock noise
  task automatic test_random_startups();
    int unsigned sent;
    int          thr;
    int          spd;
    cps_in_t     tick;
    sent = 0;
    while (sent < RandomTicks) begin
      wait_results_done();
      write_random_setup();
      thr = int'(cfg_limit) + int'(cfg_margin);
      if ($urandom_range(0, 3) == 0) begin
        send_tick(make_tick(1'b0, 1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))));
        sent++;
      end
      repeat ($urandom_range(20, 60)) begin
        tick.panel_unlocked = ($urandom_range(0, 59) != 0);
        tick.validate_on    = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 3) == 0) begin
          spd = $urandom_range(0, 511);
        end else begin
          spd = thr + int'($urandom_range(0, 4)) - 2;
          if (spd < 0) spd = 0;
          if (spd > 511) spd = 511;
        end
        tick.speed_reading = 9'(spd);
        send_tick(tick);
        sent++;
        if ($urandom_range(0, 79) == 0) wait_results_done();
      end
    end
  endtask

  // Receiver stalls: full rate, 3 of 4, random, then long stalls
  always @(posedge clk_i) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= (stall_phase[1:0] != 2'b11);
      2'd2:    out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_phase[4:0] < 5'd6);
    endcase
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    cps_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (panel_result_q.size() == 0) begin
        $error("result transaction with no tick pending: %0h", out_data_o);
        error_count++;
      end else begin
        want = panel_result_q.pop_front();
        check_field("mode", 8'(want.mode), 8'(out_data_o.mode));
        check_field("digit_enable", 8'(want.digit_enable), 8'(out_data_o.digit_enable));
        check_field("segment_lines", want.segment_lines, out_data_o.segment_lines);
        check_field("blink_lamp", 8'(want.blink_lamp), 8'(out_data_o.blink_lamp));
        check_field("urgency", 8'(want.urgency), 8'(out_data_o.urgency));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_inputs();
    test_fast_startup();
    test_long_durations();
    test_random_startups();
    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
